// ----- rtl/htq_pkg.sv -----
// shared types and constants for the heightmap triangle height query block
// no dependencies; imported by heightmap_triangle_height_query

package htq_pkg;

    // grid store geometry
    localparam int MAX_SIDE    = 64;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // field widths
    localparam int WIDX_W   = 12;
    localparam int HBYTE_W  = 8;
    localparam int Q_W      = 14;
    localparam int FRAC_W   = 8;
    localparam int CELL_W   = Q_W - FRAC_W;
    localparam int Y_W      = 17;
    localparam int GW_W     = 7;
    localparam int CL_W     = 6;

    // stream packing
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_LIMIT = 1'd1;

    localparam logic [GW_W-1:0] GRID_WIDTH_RST = 7'd33;
    localparam logic [CL_W-1:0] CELL_LIMIT_RST = 6'd32;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // divide by 7: floor(v / 7) = (v * ceil(2^19 / 7)) >> 19 for v < 2^16
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 17;
    localparam int V_W         = 16;
    localparam int PROD_W      = V_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_7 = 17'd74899;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // fallback height offset, one half in 8 fraction bits
    localparam logic signed [Y_W:0] HALF_Y  = 18'sd128;
    localparam logic signed [Y_W:0] Y_MIN_W = -18'sd65536;
    localparam logic [Y_W-1:0]      Y_MIN   = 17'h10000;

    // per-item sideband carried down the pipeline
    typedef struct packed {
        logic             cmd;
        logic             outside;
        logic [Y_W-1:0]   fb_y;
    } side_t;

endpackage

// ----- rtl/heightmap_triangle_height_query.sv -----
// heightmap triangle height query: one item per cycle sustained when the output is not stalled
// the four corner heights come from two copies of the 4096-entry store, each read at
// two addresses per cycle, so a query never waits on a memory port
// a request passes through stage registers s1 to s5 and then the output register
// rst_n clears pipeline valids and loads grid_width 33, cell_limit 32;
// height store contents are undefined until written, no clearing pass
module heightmap_triangle_height_query
    import htq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // requests
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // write_index, height_byte, query_x, query_z, current_y
    input  logic                  s_axis_tuser,  // cmd
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // height_y
    output logic                  m_axis_tuser   // outside
);

    // configuration
    logic [GW_W-1:0] grid_width_reg;
    logic [CL_W-1:0] cell_limit_reg;

    // stage valids and readies
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, out_ready;

    // stage 1: request
    side_t              s1_side;
    logic               s1_cmd_reg;
    logic [WIDX_W-1:0]  s1_widx_reg;
    logic [HBYTE_W-1:0] s1_hbyte_reg;
    logic [Q_W-1:0]     s1_qx_reg;
    logic [Q_W-1:0]     s1_qz_reg;
    logic [Y_W-1:0]     s1_cur_y_reg;

    // stage 2: base address
    side_t               s2_side_reg;
    logic [STORE_AW-1:0] s2_base_reg;
    logic [WIDX_W-1:0]   s2_widx_reg;
    logic [HBYTE_W-1:0]  s2_hbyte_reg;
    logic [FRAC_W-1:0]   s2_uf_reg;
    logic [FRAC_W-1:0]   s2_wf_reg;

    // stage 3: corner heights
    side_t              s3_side_reg;
    logic [FRAC_W-1:0]  s3_uf_reg;
    logic [FRAC_W-1:0]  s3_wf_reg;
    logic [HBYTE_W-1:0] s3_ha_reg, s3_hb_reg, s3_hc_reg, s3_hd_reg;

    // stage 4: partial products
    side_t               s4_side_reg;
    logic [HBYTE_W-1:0]  s4_h_reg;
    logic signed [19:0]  s4_p1_reg, s4_p2_reg;

    // stage 5: scaled sum plus rounding
    side_t          s5_side_reg;
    logic [V_W-1:0] s5_v_reg;

    // output
    logic [Y_W-1:0] out_y_reg;
    logic           out_outside_reg;

    // two copies of the height store
    logic [HBYTE_W-1:0] store_lo_reg [STORE_DEPTH];
    logic [HBYTE_W-1:0] store_hi_reg [STORE_DEPTH];

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign out_ready = !out_valid_reg || m_axis_tready;
    assign s5_ready  = !s5_valid_reg || out_ready;
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign s_axis_tready = s1_ready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            grid_width_reg <= GRID_WIDTH_RST;
            cell_limit_reg <= CELL_LIMIT_RST;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= s_axis_tvalid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
            if (s5_ready)
                s5_valid_reg <= s4_valid_reg;
            if (out_ready)
                out_valid_reg <= s5_valid_reg;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH: grid_width_reg <= cfg_data[GW_W-1:0];
                    CFG_CELL_LIMIT: cell_limit_reg <= cfg_data[CL_W-1:0];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1 -> 2: cell, fractions, base index, outside fallback
    // ------------------------------------------------------------------
    logic [CELL_W-1:0]  s1_x0, s1_z0;
    logic [12:0]        s1_row;
    logic [13:0]        s1_base_full;
    logic signed [Y_W:0] s1_fb_wide;

    always_comb
    begin
        s1_x0        = s1_qx_reg[Q_W-1:FRAC_W];
        s1_z0        = s1_qz_reg[Q_W-1:FRAC_W];
        s1_row       = 13'(s1_z0) * 13'(grid_width_reg);
        s1_base_full = 14'(s1_row) + 14'(s1_x0);
        s1_fb_wide   = $signed({s1_cur_y_reg[Y_W-1], s1_cur_y_reg}) - HALF_Y;

        s1_side.cmd     = s1_cmd_reg;
        s1_side.outside = (s1_x0 >= cell_limit_reg) || (s1_z0 >= cell_limit_reg);
        // saturate at the most negative height
        if (s1_fb_wide < Y_MIN_W)
            s1_side.fb_y = Y_MIN;
        else
            s1_side.fb_y = s1_fb_wide[Y_W-1:0];
    end

    // ------------------------------------------------------------------
    // stage 2 -> 3: corner addresses, store access
    // ------------------------------------------------------------------
    logic [STORE_AW-1:0] s2_addr_a, s2_addr_b, s2_addr_c, s2_addr_d;
    logic                store_we;

    // vertex indices wrap modulo the store depth
    assign s2_addr_d = s2_base_reg;
    assign s2_addr_c = s2_base_reg + STORE_AW'(1);
    assign s2_addr_a = s2_base_reg + STORE_AW'(grid_width_reg);
    assign s2_addr_b = s2_addr_a + STORE_AW'(1);

    // write lands once, when the write request leaves stage 2
    assign store_we = s2_valid_reg && (s2_side_reg.cmd == CMD_WRITE) && s3_ready;

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_lo_reg[s2_widx_reg[STORE_AW-1:0]] <= s2_hbyte_reg;
            store_hi_reg[s2_widx_reg[STORE_AW-1:0]] <= s2_hbyte_reg;
        end
        if (s3_ready)
        begin
            s3_hd_reg <= store_lo_reg[s2_addr_d];
            s3_hc_reg <= store_lo_reg[s2_addr_c];
            s3_ha_reg <= store_hi_reg[s2_addr_a];
            s3_hb_reg <= store_hi_reg[s2_addr_b];
        end
    end

    // ------------------------------------------------------------------
    // stage 3 -> 4: triangle pick and plane products
    // ------------------------------------------------------------------
    logic               s3_upper;
    logic signed [9:0]  s3_c1, s3_c2, s3_d1, s3_d2;
    logic [HBYTE_W-1:0] s3_h;
    logic signed [19:0] s3_p1, s3_p2;

    always_comb
    begin
        s3_upper = (9'(s3_uf_reg) + 9'(s3_wf_reg)) > 9'd256;
        s3_c1    = $signed({2'b00, s3_uf_reg});
        if (s3_upper)
        begin
            s3_h  = s3_ha_reg;
            s3_d1 = $signed({2'b00, s3_hb_reg}) - $signed({2'b00, s3_ha_reg});
            s3_d2 = $signed({2'b00, s3_hc_reg}) - $signed({2'b00, s3_hb_reg});
            s3_c2 = $signed(10'd256 - 10'(s3_wf_reg));
        end
        else
        begin
            s3_h  = s3_hd_reg;
            s3_d1 = $signed({2'b00, s3_hc_reg}) - $signed({2'b00, s3_hd_reg});
            s3_d2 = $signed({2'b00, s3_ha_reg}) - $signed({2'b00, s3_hd_reg});
            s3_c2 = $signed({2'b00, s3_wf_reg});
        end
        s3_p1 = 20'(s3_c1 * s3_d1);
        s3_p2 = 20'(s3_c2 * s3_d2);
    end

    // ------------------------------------------------------------------
    // stage 4 -> 5: 256*h + products, plus 3 for rounding
    // ------------------------------------------------------------------
    logic signed [19:0] s4_sum;

    assign s4_sum = $signed({4'b0000, s4_h_reg, 8'h00}) + s4_p1_reg + s4_p2_reg + 20'sd3;

    // ------------------------------------------------------------------
    // stage 5 -> out: divide by 7 and pick the result
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] s5_prod;
    logic [QUOT_W-1:0] s5_quot;
    logic [Y_W-1:0]    s5_y;

    always_comb
    begin
        s5_prod = PROD_W'(s5_v_reg) * PROD_W'(RECIP_7);
        s5_quot = s5_prod[PROD_W-1:RECIP_SHIFT];
        if (s5_side_reg.cmd == CMD_WRITE)
            s5_y = '0;
        else if (s5_side_reg.outside)
            s5_y = s5_side_reg.fb_y;
        else
            s5_y = Y_W'(s5_quot);
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_ready && s_axis_tvalid)
        begin
            s1_cmd_reg   <= s_axis_tuser;
            s1_widx_reg  <= s_axis_tdata[11:0];
            s1_hbyte_reg <= s_axis_tdata[19:12];
            s1_qx_reg    <= s_axis_tdata[33:20];
            s1_qz_reg    <= s_axis_tdata[47:34];
            s1_cur_y_reg <= s_axis_tdata[64:48];
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_side_reg  <= s1_side;
            s2_base_reg  <= s1_base_full[STORE_AW-1:0];
            s2_widx_reg  <= s1_widx_reg;
            s2_hbyte_reg <= s1_hbyte_reg;
            s2_uf_reg    <= s1_qx_reg[FRAC_W-1:0];
            s2_wf_reg    <= s1_qz_reg[FRAC_W-1:0];
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_side_reg <= s2_side_reg;
            s3_uf_reg   <= s2_uf_reg;
            s3_wf_reg   <= s2_wf_reg;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_side_reg <= s3_side_reg;
            s4_h_reg    <= s3_h;
            s4_p1_reg   <= s3_p1;
            s4_p2_reg   <= s3_p2;
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_side_reg <= s4_side_reg;
            s5_v_reg    <= s4_sum[V_W-1:0];
        end
        if (out_ready && s5_valid_reg)
        begin
            out_y_reg       <= s5_y;
            out_outside_reg <= (s5_side_reg.cmd == CMD_QUERY) && s5_side_reg.outside;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_y_reg);
    assign m_axis_tuser  = out_outside_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> s1_valid_reg)
        else $error("accepted request did not reach stage 1");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg && !out_ready |=> s5_valid_reg && $stable(s5_v_reg))
        else $error("stalled item in stage 5 was lost or changed");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg && (s5_side_reg.cmd == CMD_QUERY) && !s5_side_reg.outside
        |-> (s5_v_reg >= 16'd3) && (s5_v_reg <= 16'd65283))
        else $error("interpolated sum outside the convex range");

    a_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_outside_reg |-> out_y_reg <= 17'd9326)
        else $error("terrain height above the largest scaled sample");

endmodule
